@@ design/date_time_text_validator_macros.svh @@
// assertion macros shared by the validator rtl
`ifndef DATE_TIME_TEXT_VALIDATOR_MACROS_SVH
`define DATE_TIME_TEXT_VALIDATOR_MACROS_SVH

`ifndef SYNTHESIS
`define DTV_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("date/time validator check failed");
`define DTV_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("date/time validator check failed");
`else
`define DTV_ASSERT(label, prop)
`define DTV_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ design/dtv_pkg.sv @@
package dtv_pkg;

    localparam int YEAR_DIGITS = 6;
    localparam int YEAR_ACC_W  = $clog2(10 ** YEAR_DIGITS);
    localparam int YCNT_W      = $clog2(YEAR_DIGITS + 1);
    localparam int YEAR_W      = 21;
    localparam int YEAR_EXT_W  = (YEAR_ACC_W > YEAR_W) ? YEAR_ACC_W : YEAR_W;
    localparam int CPOS_W      = 5;
    localparam int ACC_W       = 7;
    localparam int MILLIS_W    = 16;

    localparam logic [CPOS_W-1:0] CPOS_MAX      = 5'd31;
    localparam logic [CPOS_W-1:0] TPOS_HOUR_LO  = 5'd1;
    localparam logic [CPOS_W-1:0] TPOS_COLON1   = 5'd2;
    localparam logic [CPOS_W-1:0] TPOS_MIN_LO   = 5'd4;
    localparam logic [CPOS_W-1:0] TPOS_COLON2   = 5'd5;
    localparam logic [CPOS_W-1:0] TPOS_SEC_LO   = 5'd7;
    localparam logic [CPOS_W-1:0] TPOS_DOT      = 5'd8;
    localparam logic [CPOS_W-1:0] TPOS_LEN      = 5'd12;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [31:0] GREG_YEAR   = 32'd1582;
    localparam logic [ACC_W-1:0] MON_FEB    = 7'd2;
    localparam logic [ACC_W-1:0] MON_OCT    = 7'd10;
    localparam logic [ACC_W-1:0] MON_MAX    = 7'd12;
    localparam logic [ACC_W-1:0] GAP_FIRST  = 7'd5;
    localparam logic [ACC_W-1:0] GAP_LAST   = 7'd14;
    localparam logic [ACC_W-1:0] HOURS      = 7'd24;
    localparam logic [ACC_W-1:0] MINUTES    = 7'd60;
    localparam logic [MILLIS_W-1:0] SECONDS = 16'd60;
    localparam logic [MILLIS_W-1:0] MILLIS_LIMIT = 16'd60000;

    typedef enum logic [2:0] {
        STG_SIGN,
        STG_YEAR,
        STG_MON_HI,
        STG_MON_LO,
        STG_SEP,
        STG_DAY_HI,
        STG_DAY_LO,
        STG_DONE
    } date_stage_t;

    typedef enum logic {
        KIND_DATE = 1'b0,
        KIND_TIME = 1'b1
    } kind_t;

    // first member sits in the high bits, so fields are listed top down
    typedef struct packed {
        logic [5:0]          pad;
        logic [MILLIS_W-1:0] millis;
        logic [5:0]          minute;
        logic [4:0]          hour;
        logic [4:0]          day;
        logic [3:0]          month;
        logic [YEAR_W-1:0]   year;
        logic                valid_res;
    } res_data_t;

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd2:    n = 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

@@ design/date_time_text_validator.sv @@
// channel | dir | tdata                           | tuser      | tlast
// s       | in  | ch                              | op         | last
// m       | out | valid_res,year,month,day,hour,  | part       | -
//         |     | minute,millis,pad               |            |
//
// one character per cycle while no waiting result holds a last character; a character
// waits in the input register and the last one of a string loads its result into the
// output register as it leaves, so the result is offered from the output register
// rst_n clears the parse state and both valid flags at once
// a waiting result stalls only a last character behind it; other characters keep
// moving while m_tready is low
`include "date_time_text_validator_macros.svh"

module date_time_text_validator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch
    input  logic        s_tuser,   // op
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // valid_res, year, month, day, hour, minute, millis, pad
    output logic        m_tuser    // part
);
    import dtv_pkg::*;

    // input register
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_ch_reg;
    logic       in_last_reg;

    // parse state
    logic [CPOS_W-1:0]     char_pos_reg, char_pos_next;
    date_stage_t           stage_reg, stage_next;
    logic                  failed_reg, failed_next;
    logic                  negative_reg, negative_next;
    logic [YEAR_ACC_W-1:0] year_acc_reg, year_acc_next;
    logic [YCNT_W-1:0]     ycnt_reg, ycnt_next;
    logic [3:0][3:0]       yhist_reg, yhist_next;
    logic [ACC_W-1:0]      first_acc_reg, first_acc_next;
    logic [ACC_W-1:0]      second_acc_reg, second_acc_next;
    logic [MILLIS_W-1:0]   millis_acc_reg, millis_acc_next;
    kind_t                 kind_reg, kind_next;

    // output register
    logic      out_valid_reg;
    res_data_t out_data_reg, out_data_next;
    kind_t     out_part_reg;

    logic       out_free;
    logic       proceed;
    logic       out_load;
    logic       is_dig;
    logic [3:0] dval;
    logic [7:0] dsub;

    logic [31:0]           yr32;
    logic                  div100;
    logic                  div400;
    logic                  leap;
    logic [4:0]            mlen;
    logic                  date_ok;
    logic                  time_ok;
    logic [YEAR_EXT_W-1:0] year_ext;

    assign out_free = !out_valid_reg || m_tready;
    assign proceed  = in_valid_reg && (!in_last_reg || out_free);
    assign out_load = proceed && in_last_reg;
    assign s_tready = !in_valid_reg || proceed;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_part_reg;

    assign is_dig = (in_ch_reg >= CH_ZERO) && (in_ch_reg <= CH_NINE);
    assign dsub   = in_ch_reg - CH_ZERO;
    assign dval   = is_dig ? dsub[3:0] : 4'd0;

    // next parse state for the character in the input register
    always_comb
    begin
        char_pos_next   = char_pos_reg;
        stage_next      = stage_reg;
        failed_next     = failed_reg;
        negative_next   = negative_reg;
        year_acc_next   = year_acc_reg;
        ycnt_next       = ycnt_reg;
        yhist_next      = yhist_reg;
        first_acc_next  = first_acc_reg;
        second_acc_next = second_acc_reg;
        millis_acc_next = millis_acc_reg;
        kind_next       = kind_reg;

        if (char_pos_reg == '0)
        begin
            kind_next = kind_t'(in_op_reg);
        end
        else if (in_op_reg != kind_reg)
        begin
            failed_next = 1'b1;
        end

        if (kind_next == KIND_DATE)
        begin
            case (stage_reg)
                STG_SIGN:
                begin
                    if (in_ch_reg == CH_PLUS)
                        negative_next = 1'b0;
                    else if (in_ch_reg == CH_MINUS)
                        negative_next = 1'b1;
                    else
                        failed_next = 1'b1;
                    stage_next = STG_YEAR;
                end
                STG_YEAR:
                begin
                    if (is_dig)
                    begin
                        if (ycnt_reg < YCNT_W'(YEAR_DIGITS))
                        begin
                            year_acc_next = (year_acc_reg << 3) + (year_acc_reg << 1)
                                          + YEAR_ACC_W'(dval);
                            ycnt_next     = ycnt_reg + YCNT_W'(1);
                            yhist_next[3] = yhist_reg[2];
                            yhist_next[2] = yhist_reg[1];
                            yhist_next[1] = yhist_reg[0];
                            yhist_next[0] = dval;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else if (in_ch_reg == CH_MINUS)
                    begin
                        if (ycnt_reg == '0)
                            failed_next = 1'b1;
                        stage_next = STG_MON_HI;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                STG_MON_HI, STG_MON_LO:
                begin
                    if (is_dig)
                        first_acc_next = (first_acc_reg << 3) + (first_acc_reg << 1)
                                       + ACC_W'(dval);
                    else
                        failed_next = 1'b1;
                    stage_next = date_stage_t'(stage_reg + 3'd1);
                end
                STG_SEP:
                begin
                    if (in_ch_reg != CH_MINUS)
                        failed_next = 1'b1;
                    stage_next = STG_DAY_HI;
                end
                STG_DAY_HI, STG_DAY_LO:
                begin
                    if (is_dig)
                        second_acc_next = (second_acc_reg << 3) + (second_acc_reg << 1)
                                        + ACC_W'(dval);
                    else
                        failed_next = 1'b1;
                    stage_next = date_stage_t'(stage_reg + 3'd1);
                end
                default:
                begin
                    failed_next = 1'b1;
                end
            endcase
        end
        else
        begin
            if (char_pos_reg >= TPOS_LEN)
                failed_next = 1'b1;
            else if (char_pos_reg == TPOS_COLON1 || char_pos_reg == TPOS_COLON2)
            begin
                if (in_ch_reg != CH_COLON)
                    failed_next = 1'b1;
            end
            else if (char_pos_reg == TPOS_DOT)
            begin
                if (in_ch_reg != CH_DOT)
                    failed_next = 1'b1;
            end
            else if (!is_dig)
                failed_next = 1'b1;
            else if (char_pos_reg <= TPOS_HOUR_LO)
                first_acc_next = (first_acc_reg << 3) + (first_acc_reg << 1) + ACC_W'(dval);
            else if (char_pos_reg <= TPOS_MIN_LO)
                second_acc_next = (second_acc_reg << 3) + (second_acc_reg << 1)
                                + ACC_W'(dval);
            else
            begin
                millis_acc_next = (millis_acc_reg << 3) + (millis_acc_reg << 1)
                                + MILLIS_W'(dval);
                // whole seconds are complete after the second seconds digit
                if (char_pos_reg == TPOS_SEC_LO && millis_acc_next >= SECONDS)
                    failed_next = 1'b1;
            end
        end

        if (char_pos_reg != CPOS_MAX)
            char_pos_next = char_pos_reg + CPOS_W'(1);
    end

    // result of a string that ends with the current character; a complete date
    // leaves year and month untouched on its last character, so the registered
    // values are used for them
    always_comb
    begin
        yr32     = 32'(year_acc_reg);
        div100   = (yhist_reg[1] == 4'd0) && (yhist_reg[0] == 4'd0);
        div400   = div100 && ((({yhist_reg[3][0], 1'b0}) + yhist_reg[2][1:0]) == 2'd0);
        leap     = (year_acc_reg[1:0] == 2'b00)
                 && (negative_reg || (yr32 <= GREG_YEAR) || !div100 || div400);
        mlen     = month_days(first_acc_reg[3:0])
                 + 5'((first_acc_reg == MON_FEB) && leap);
        year_ext = YEAR_EXT_W'(year_acc_reg);
        if (negative_reg)
            year_ext = -year_ext;

        date_ok = !failed_next && (stage_next == STG_DONE)
                && (first_acc_reg >= 7'd1) && (first_acc_reg <= MON_MAX)
                && (second_acc_next >= 7'd1) && (second_acc_next <= ACC_W'(mlen))
                && !(!negative_reg && (yr32 == GREG_YEAR) && (first_acc_reg == MON_OCT)
                     && (second_acc_next >= GAP_FIRST) && (second_acc_next <= GAP_LAST));

        time_ok = !failed_next && (char_pos_next == TPOS_LEN)
                && (first_acc_next < HOURS) && (second_acc_next < MINUTES);

        out_data_next = '0;
        if (kind_next == KIND_DATE)
        begin
            if (date_ok)
            begin
                out_data_next.valid_res = 1'b1;
                out_data_next.year      = year_ext[YEAR_W-1:0];
                out_data_next.month     = first_acc_reg[3:0];
                out_data_next.day       = second_acc_next[4:0];
            end
        end
        else
        begin
            if (time_ok)
            begin
                out_data_next.valid_res = 1'b1;
                out_data_next.hour      = first_acc_next[4:0];
                out_data_next.minute    = second_acc_next[5:0];
                out_data_next.millis    = millis_acc_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            char_pos_reg   <= '0;
            stage_reg      <= STG_SIGN;
            failed_reg     <= 1'b0;
            negative_reg   <= 1'b0;
            year_acc_reg   <= '0;
            ycnt_reg       <= '0;
            yhist_reg      <= '0;
            first_acc_reg  <= '0;
            second_acc_reg <= '0;
            millis_acc_reg <= '0;
            kind_reg       <= KIND_DATE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;

            if (proceed)
            begin
                if (in_last_reg)
                begin
                    char_pos_reg   <= '0;
                    stage_reg      <= STG_SIGN;
                    failed_reg     <= 1'b0;
                    negative_reg   <= 1'b0;
                    year_acc_reg   <= '0;
                    ycnt_reg       <= '0;
                    yhist_reg      <= '0;
                    first_acc_reg  <= '0;
                    second_acc_reg <= '0;
                    millis_acc_reg <= '0;
                    kind_reg       <= KIND_DATE;
                end
                else
                begin
                    char_pos_reg   <= char_pos_next;
                    stage_reg      <= stage_next;
                    failed_reg     <= failed_next;
                    negative_reg   <= negative_next;
                    year_acc_reg   <= year_acc_next;
                    ycnt_reg       <= ycnt_next;
                    yhist_reg      <= yhist_next;
                    first_acc_reg  <= first_acc_next;
                    second_acc_reg <= second_acc_next;
                    millis_acc_reg <= millis_acc_next;
                    kind_reg       <= kind_next;
                end
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
            out_part_reg <= kind_next;
        end
    end

    `DTV_ASSERT(a_last_gives_result, out_load |=> out_valid_reg)
    `DTV_ASSERT(a_mid_char_no_result,
        (in_valid_reg && !in_last_reg && !out_valid_reg) |=> !out_valid_reg)
    `DTV_ASSERT(a_clear_after_last,
        out_load |=> (char_pos_reg == '0) && (stage_reg == STG_SIGN) && !failed_reg)
    `DTV_ASSERT(a_date_fields_sane,
        (out_valid_reg && (out_part_reg == KIND_DATE) && out_data_reg.valid_res)
        |-> (out_data_reg.month != 4'd0) && (out_data_reg.month <= 4'd12)
            && (out_data_reg.day != 5'd0))
    `DTV_ASSERT_ALWAYS(a_time_millis_range,
        (out_valid_reg && (out_part_reg == KIND_TIME) && out_data_reg.valid_res)
        |-> (out_data_reg.millis < MILLIS_LIMIT))

endmodule

@@ dv/date_time_text_validator_test.sv @@
module date_time_text_validator_test;
    import dtv_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1050;
    localparam int HOLD_CYCLES  = 300;
    localparam int unsigned DAYS_IN_MONTH [12] =
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned ODD_YEARS [12] =
        '{1582, 2000, 1900, 1600, 1700, 1500, 400, 100, 4, 0, 2024, 2023};

    typedef logic [7:0] text_q [$];

    typedef struct packed {
        logic        part;
        logic        ok;
        logic [20:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] millis;
    } stamp_t;

    // mirrors the parse of one string and keeps the stamps still owed by the block
    class parse_tracker;
        int unsigned char_pos;
        date_stage_t stage;
        bit          failed;
        bit          negative;
        int unsigned year_acc;
        int unsigned year_digits;
        int unsigned first_acc;
        int unsigned second_acc;
        int unsigned millis_acc;
        kind_t       kind;
        stamp_t      pending_stamps [$];
        int          errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            char_pos    = 0;
            stage       = STG_SIGN;
            failed      = 0;
            negative    = 0;
            year_acc    = 0;
            year_digits = 0;
            first_acc   = 0;
            second_acc  = 0;
            millis_acc  = 0;
            kind        = KIND_DATE;
        endfunction

        function void date_char(logic [7:0] c, bit dig, int unsigned d);
            case (stage)
                STG_SIGN:
                begin
                    if (c == CH_PLUS) negative = 0;
                    else if (c == CH_MINUS) negative = 1;
                    else failed = 1;
                    stage = STG_YEAR;
                end
                STG_YEAR:
                begin
                    if (dig) begin
                        if (year_digits < YEAR_DIGITS) begin
                            year_acc = year_acc * 10 + d;
                            year_digits++;
                        end
                        else failed = 1;
                    end
                    else if (c == CH_MINUS) begin
                        if (year_digits == 0) failed = 1;
                        stage = STG_MON_HI;
                    end
                    else failed = 1;
                end
                STG_MON_HI, STG_MON_LO:
                begin
                    if (dig) first_acc = first_acc * 10 + d;
                    else failed = 1;
                    stage = date_stage_t'(stage + 1);
                end
                STG_SEP:
                begin
                    if (c != CH_MINUS) failed = 1;
                    stage = STG_DAY_HI;
                end
                STG_DAY_HI, STG_DAY_LO:
                begin
                    if (dig) second_acc = second_acc * 10 + d;
                    else failed = 1;
                    stage = date_stage_t'(stage + 1);
                end
                default: failed = 1;
            endcase
        endfunction

        function void time_char(logic [7:0] c, bit dig, int unsigned d);
            if (char_pos >= TPOS_LEN) failed = 1;
            else if (char_pos == TPOS_COLON1 || char_pos == TPOS_COLON2) begin
                if (c != CH_COLON) failed = 1;
            end
            else if (char_pos == TPOS_DOT) begin
                if (c != CH_DOT) failed = 1;
            end
            else if (!dig) failed = 1;
            else if (char_pos < TPOS_COLON1) first_acc = first_acc * 10 + d;
            else if (char_pos < TPOS_COLON2) second_acc = second_acc * 10 + d;
            else begin
                // seconds and fraction run together as one number
                millis_acc = millis_acc * 10 + d;
                if (char_pos == TPOS_SEC_LO && millis_acc >= 60) failed = 1;
            end
        endfunction

        function void close_string();
            stamp_t      s;
            bit          ok;
            int unsigned lim;
            logic [31:0] yv;
            s = '0;
            s.part = kind;
            if (kind == KIND_DATE) begin
                ok = !failed && stage == STG_DONE && first_acc >= 1 && first_acc <= 12;
                if (ok) begin
                    lim = DAYS_IN_MONTH[first_acc - 1];
                    // julian rule for negative years and up to 1582
                    if (first_acc == 2 && year_acc % 4 == 0 &&
                        (negative || year_acc <= 1582 || year_acc % 100 != 0 ||
                         year_acc % 400 == 0))
                        lim++;
                    if (second_acc < 1 || second_acc > lim) ok = 0;
                    if (!negative && year_acc == 1582 && first_acc == 10 &&
                        second_acc >= 5 && second_acc <= 14)
                        ok = 0;
                end
                if (ok) begin
                    yv = negative ? 32'd0 - year_acc : year_acc;
                    s.ok    = 1;
                    s.year  = yv[20:0];
                    s.month = first_acc[3:0];
                    s.day   = second_acc[4:0];
                end
            end
            else begin
                ok = !failed && char_pos == TPOS_LEN && first_acc < 24 && second_acc < 60;
                if (ok) begin
                    s.ok     = 1;
                    s.hour   = first_acc[4:0];
                    s.minute = second_acc[5:0];
                    s.millis = millis_acc[15:0];
                end
            end
            pending_stamps.push_back(s);
            clear();
        endfunction

        function void note_char(bit op, logic [7:0] c, bit is_last);
            bit          dig;
            int unsigned d;
            dig = c >= CH_ZERO && c <= CH_NINE;
            d   = dig ? c - CH_ZERO : 0;
            if (char_pos == 0) kind = kind_t'(op);
            else if (op != kind) failed = 1;
            if (kind == KIND_DATE) date_char(c, dig, d);
            else time_char(c, dig, d);
            if (char_pos < CPOS_MAX) char_pos++;
            if (is_last) close_string();
        endfunction

        function void check_result(logic [63:0] tdata, logic part);
            res_data_t r;
            stamp_t    e;
            r = res_data_t'(tdata);
            if (pending_stamps.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: part %0d tdata %h", part, tdata);
                return;
            end
            e = pending_stamps.pop_front();
            if (part !== e.part || r.valid_res !== e.ok || r.year !== e.year ||
                r.month !== e.month || r.day !== e.day || r.hour !== e.hour ||
                r.minute !== e.minute || r.millis !== e.millis) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch expected: part %0d ok %0d %0d-%0d-%0d %0d:%0d %0d",
                             e.part, e.ok, $signed(e.year), e.month, e.day,
                             e.hour, e.minute, e.millis);
                    $display("           actual: part %0d ok %0d %0d-%0d-%0d %0d:%0d %0d",
                             part, r.valid_res, $signed(r.year), r.month, r.day,
                             r.hour, r.minute, r.millis);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;

    parse_tracker sb = new();
    bit           idle_on;
    bit           hold_req;
    int           chars_sent;
    int           cycle_count;

    date_time_text_validator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && s_tvalid && s_tready)
            sb.note_char(s_tuser, s_tdata, s_tlast);
        if (rst_n === 1'b1 && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // receiver side: random stalls plus one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_item(bit op, logic [7:0] c, bit is_last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= op;
        s_tlast  <= is_last;
        do @(posedge clk); while (!s_tready);
        chars_sent++;
    endtask

    // odd_pos picks one character whose op is flipped, -1 for none
    task automatic send_text(text_q t, bit op, int odd_pos);
        for (int i = 0; i < t.size(); i++)
            send_item((i == odd_pos) ? ~op : op, t[i], i == t.size() - 1);
    endtask

    function automatic text_q txt(string s);
        text_q t;
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        return t;
    endfunction

    function automatic void push_num(ref text_q t, input int unsigned v, input int n);
        int unsigned p;
        for (int k = n - 1; k >= 0; k--) begin
            p = 1;
            repeat (k) p = p * 10;
            t.push_back(8'(CH_ZERO + (v / p) % 10));
        end
    endfunction

    function automatic text_q make_date();
        text_q       t;
        int          n;
        int unsigned p;
        int unsigned y;
        int unsigned m;
        int unsigned dd;
        t.push_back(($urandom_range(0, 4) == 0) ? CH_MINUS : CH_PLUS);
        case ($urandom_range(0, 3))
            0:
            begin
                n = 4;
                y = ODD_YEARS[$urandom_range(0, 11)];
            end
            1:
            begin
                n = $urandom_range(1, 6);
                p = 1;
                repeat (n) p = p * 10;
                y = $urandom_range(0, p - 1);
            end
            2:
            begin
                n = 6;
                y = $urandom_range(0, 999999);
            end
            default:
            begin
                // occasionally one digit too many
                n = $urandom_range(1, 7);
                p = 1;
                repeat (n) p = p * 10;
                y = $urandom_range(0, p - 1);
            end
        endcase
        push_num(t, y, n);
        t.push_back(CH_MINUS);
        if (y == 1582 && $urandom_range(0, 1) == 0) m = 10;
        else if ($urandom_range(0, 3) == 0) m = 2;
        else if ($urandom_range(0, 9) == 0) m = $urandom_range(0, 19);
        else m = $urandom_range(1, 12);
        push_num(t, m, 2);
        t.push_back(CH_MINUS);
        if (y == 1582 && m == 10) dd = $urandom_range(1, 20);
        else begin
            case ($urandom_range(0, 3))
                0: dd = $urandom_range(0, 39);
                1: dd = $urandom_range(28, 31);
                default:
                    dd = (m >= 1 && m <= 12) ? $urandom_range(1, DAYS_IN_MONTH[m - 1])
                                             : $urandom_range(1, 31);
            endcase
        end
        push_num(t, dd, 2);
        return t;
    endfunction

    function automatic text_q make_time();
        text_q t;
        bit    wide;
        wide = $urandom_range(0, 4) == 0;
        push_num(t, wide ? $urandom_range(0, 29) : $urandom_range(0, 23), 2);
        t.push_back(CH_COLON);
        push_num(t, wide ? $urandom_range(0, 69) : $urandom_range(0, 59), 2);
        t.push_back(CH_COLON);
        push_num(t, wide ? $urandom_range(0, 69) : $urandom_range(0, 59), 2);
        t.push_back(CH_DOT);
        push_num(t, $urandom_range(0, 999), 3);
        return t;
    endfunction

    function automatic logic [7:0] junk_char();
        string pool;
        pool = "0123456789+-:. x";
        if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    initial
    begin
        text_q t;
        bit    op;
        int    odd;
        int    strings;
        int    cut;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        cycle_count = 0;
        idle_on  = 1;
        hold_req = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // leap rule on both sides of 1582, calendar gap, year limits
        send_text(txt("+2024-02-29"), KIND_DATE, -1);
        send_text(txt("+1900-02-29"), KIND_DATE, -1);
        send_text(txt("+1500-02-29"), KIND_DATE, -1);
        send_text(txt("+2000-02-29"), KIND_DATE, -1);
        send_text(txt("-0100-02-29"), KIND_DATE, -1);
        send_text(txt("+1582-10-04"), KIND_DATE, -1);
        send_text(txt("+1582-10-05"), KIND_DATE, -1);
        send_text(txt("+1582-10-14"), KIND_DATE, -1);
        send_text(txt("+1582-10-15"), KIND_DATE, -1);
        send_text(txt("-1582-10-10"), KIND_DATE, -1);
        send_text(txt("+999999-12-31"), KIND_DATE, -1);
        send_text(txt("-999999-01-01"), KIND_DATE, -1);
        send_text(txt("+0000001-01-01"), KIND_DATE, -1);
        send_text(txt("+-01-01"), KIND_DATE, -1);
        send_text(txt("-0-01-01"), KIND_DATE, -1);
        send_text(txt("+2023-13-01"), KIND_DATE, -1);
        send_text(txt("+2023-04-31"), KIND_DATE, -1);
        send_text(txt("+2023-01-011"), KIND_DATE, -1);
        send_text(txt("+2023-01"), KIND_DATE, -1);
        send_text(txt("2023-01-01"), KIND_DATE, -1);
        send_text(txt("+"), KIND_DATE, -1);
        send_item(KIND_DATE, 8'h00, 1'b1);
        send_item(KIND_TIME, 8'hFF, 1'b1);
        send_text(txt("23:59:59.999"), KIND_TIME, -1);
        send_text(txt("00:00:00.000"), KIND_TIME, -1);
        send_text(txt("24:00:00.000"), KIND_TIME, -1);
        send_text(txt("12:60:00.000"), KIND_TIME, -1);
        send_text(txt("12:00:60.000"), KIND_TIME, -1);
        send_text(txt("12:00:00.0000"), KIND_TIME, -1);
        send_text(txt("12:00:00.00"), KIND_TIME, -1);
        // mixed kinds inside one string
        send_text(txt("+2023-05-17"), KIND_DATE, 4);
        send_text(txt("10:20:30.400"), KIND_TIME, 0);

        chars_sent = 0;
        strings    = 0;
        while (chars_sent < RANDOM_ITEMS) begin
            if (chars_sent > RANDOM_ITEMS * 85 / 100) idle_on = 0;
            if (strings == 30) begin
                // results back up while short strings keep coming
                hold_req = 1;
                repeat (24) send_text(txt(":"), KIND_TIME, -1);
            end
            op  = $urandom_range(0, 1);
            t   = op ? make_time() : make_date();
            odd = -1;
            case ($urandom_range(0, 9))
                7: t[$urandom_range(0, t.size() - 1)] = junk_char();
                8:
                begin
                    if ($urandom_range(0, 1) == 0) begin
                        cut = $urandom_range(1, t.size() - 1);
                        while (t.size() > cut) void'(t.pop_back());
                    end
                    else repeat ($urandom_range(1, 3)) t.push_back(junk_char());
                end
                9:
                begin
                    t.delete();
                    repeat ($urandom_range(1, 14)) t.push_back(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
            if ($urandom_range(0, 19) == 0) odd = $urandom_range(0, t.size() - 1);
            send_text(t, op, odd);
            strings++;
        end
        s_tvalid <= 1'b0;

        while (sb.pending_stamps.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_stamps.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+design
design/dtv_pkg.sv
design/date_time_text_validator.sv
dv/date_time_text_validator_test.sv
